// ===== hw/rtl/absd_pkg.sv =====
// Shared widths, register map and status types for the accelerometer conditioner.
`default_nettype none

package absd_pkg;

	// Field and state widths
	localparam int SAMPLE_W = 12;
	localparam int AVG_W    = 21;
	localparam int OFFSET_W = 20;
	localparam int SUM_W    = 19;
	localparam int GAIN_W   = 9;
	localparam int DZ_W     = 8;
	localparam int FRAC_W   = 8;

	// Bias numerator: sum magnitude in Q.8
	localparam int NUM_W = SUM_W - 1 + FRAC_W;

	// APB register map
	localparam int ADDR_W  = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_GAIN     = 1'b0;
	localparam logic REG_DEADZONE = 1'b1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd77;
	localparam logic [DZ_W-1:0]   DZ_RESET   = 8'd15;

	// Item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CAL    = 1'b1;

	// Divider status seen by the top level
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/accel_bias_smooth_deadzone.sv =====
// A sample passes the input register, then the result register; one item per cycle unless the
// divider is busy or the result slot is blocked. The attempt that ends a calibration run loads
// both sum magnitudes into a reciprocal-multiply divider; the next item waits as the biases are written.
// Calibrate items and samples inside a run produce no result; neither do failed reads.
// Reset clears flags, sums, averages and biases, and loads gain 77 and deadzone 15.
`default_nettype none

module accel_bias_smooth_deadzone import absd_pkg::*; #(
	parameter int CAL_SAMPLES = 100
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// Input items
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       kind,
	input  wire logic signed [SAMPLE_W-1:0] sample_x_mg,
	input  wire logic signed [SAMPLE_W-1:0] sample_y_mg,
	input  wire logic                       read_good,
	// Results
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [AVG_W-1:0]         smooth_x,
	output logic signed [AVG_W-1:0]         smooth_y,
	output logic                            is_calibrated,
	// APB
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [ADDR_W-1:0]          paddr,
	input  wire logic [PDATA_W-1:0]         pwdata,
	output logic [PDATA_W-1:0]              prdata,
	output logic                            pready
);

	localparam int ATT_W = $clog2(CAL_SAMPLES + 1);
	localparam logic [ATT_W-1:0] LAST_ATT = ATT_W'(CAL_SAMPLES - 1);

	// Configuration
	logic [GAIN_W-1:0] gain_q;
	logic [DZ_W-1:0]   dz_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			dz_q   <= DZ_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_GAIN:     gain_q <= pwdata[GAIN_W-1:0];
				REG_DEADZONE: dz_q   <= pwdata[DZ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_GAIN:     prdata = PDATA_W'(gain_q);
			REG_DEADZONE: prdata = PDATA_W'(dz_q);
			default:      prdata = '0;
		endcase
	end

	// Input register
	logic                       valid_s1;
	logic                       kind_s1;
	logic signed [SAMPLE_W-1:0] sx_s1;
	logic signed [SAMPLE_W-1:0] sy_s1;
	logic                       good_s1;

	// State
	logic signed [AVG_W-1:0]    avg_x_q, avg_y_q;
	logic signed [OFFSET_W-1:0] off_x_q, off_y_q;
	logic signed [SUM_W-1:0]    sum_x_q, sum_y_q;
	logic [ATT_W-1:0]           att_q;
	logic                       calibrating_q;
	logic                       calibrated_q;

	// Result register
	logic                       out_valid_q;
	logic signed [AVG_W-1:0]    smooth_x_q, smooth_y_q;
	logic                       is_cal_q;

	div_stat_t                  stat_x, stat_y;
	logic signed [OFFSET_W-1:0] quo_x, quo_y;
	logic                       div_busy;
	logic                       div_done;

	logic                       is_cal_item;
	logic                       emits;
	logic                       s1_go;
	logic                       run_end;
	logic                       emit;
	logic signed [SUM_W-1:0]    sum_x_next, sum_y_next;
	logic [SUM_W-1:0]           abs_x, abs_y;
	logic [SUM_W-2:0]           mag_x, mag_y;
	logic signed [AVG_W-1:0]    avg_x_next, avg_y_next;

	assign div_busy = stat_x.busy | stat_y.busy;
	assign div_done = stat_x.done & stat_y.done;

	// Stage control: hold while the divider works or the result slot is blocked
	always_comb begin
		is_cal_item = (kind_s1 == KIND_CAL);
		emits       = !is_cal_item && !calibrating_q && good_s1;
		s1_go       = valid_s1 && !div_busy && (!emits || !out_valid_q || out_ready);
		in_ready    = !valid_s1 || s1_go;
		emit        = s1_go && emits;
		run_end     = s1_go && !is_cal_item && calibrating_q && (att_q == LAST_ATT);
	end

	// Calibration sums including the current sample
	always_comb begin
		sum_x_next = sum_x_q + (good_s1 ? SUM_W'(sx_s1) : SUM_W'(0));
		sum_y_next = sum_y_q + (good_s1 ? SUM_W'(sy_s1) : SUM_W'(0));
		abs_x = sum_x_next[SUM_W-1] ? -sum_x_next : sum_x_next;
		abs_y = sum_y_next[SUM_W-1] ? -sum_y_next : sum_y_next;
		mag_x = abs_x[SUM_W-2:0];
		mag_y = abs_y[SUM_W-2:0];
	end

	absd_div #(
		.DIVISOR (CAL_SAMPLES),
		.N_W     (NUM_W),
		.QUO_W   (OFFSET_W)
	) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (run_end),
		.num    ({mag_x, FRAC_W'(0)}),
		.neg    (sum_x_next[SUM_W-1]),
		.stat   (stat_x),
		.quo    (quo_x)
	);

	absd_div #(
		.DIVISOR (CAL_SAMPLES),
		.N_W     (NUM_W),
		.QUO_W   (OFFSET_W)
	) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (run_end),
		.num    ({mag_y, FRAC_W'(0)}),
		.neg    (sum_y_next[SUM_W-1]),
		.stat   (stat_y),
		.quo    (quo_y)
	);

	absd_ema u_ema_x (
		.sample     (sx_s1),
		.offset     (off_x_q),
		.use_offset (calibrated_q),
		.avg        (avg_x_q),
		.gain       (gain_q),
		.deadzone   (dz_q),
		.avg_next   (avg_x_next)
	);

	absd_ema u_ema_y (
		.sample     (sy_s1),
		.offset     (off_y_q),
		.use_offset (calibrated_q),
		.avg        (avg_y_q),
		.gain       (gain_q),
		.deadzone   (dz_q),
		.avg_next   (avg_y_next)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			sx_s1   <= sample_x_mg;
			sy_s1   <= sample_y_mg;
			good_s1 <= read_good;
		end
	end

	// Conditioner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_x_q       <= '0;
			avg_y_q       <= '0;
			off_x_q       <= '0;
			off_y_q       <= '0;
			sum_x_q       <= '0;
			sum_y_q       <= '0;
			att_q         <= '0;
			calibrating_q <= 1'b0;
			calibrated_q  <= 1'b0;
		end else begin
			if (div_done) begin
				off_x_q      <= quo_x;
				off_y_q      <= quo_y;
				calibrated_q <= 1'b1;
			end
			if (s1_go) begin
				if (is_cal_item) begin
					calibrating_q <= 1'b1;
					att_q         <= '0;
					sum_x_q       <= '0;
					sum_y_q       <= '0;
				end else if (calibrating_q) begin
					sum_x_q <= sum_x_next;
					sum_y_q <= sum_y_next;
					if (run_end) begin
						att_q         <= '0;
						calibrating_q <= 1'b0;
						avg_x_q       <= '0;
						avg_y_q       <= '0;
					end else begin
						att_q <= att_q + 1'b1;
					end
				end else if (good_s1) begin
					avg_x_q <= avg_x_next;
					avg_y_q <= avg_y_next;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			smooth_x_q <= avg_x_next;
			smooth_y_q <= avg_y_next;
			is_cal_q   <= calibrated_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign smooth_x      = smooth_x_q;
	assign smooth_y      = smooth_y_q;
	assign is_calibrated = is_cal_q;

	// No item advances while a bias is being computed
	a_hold_on_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !s1_go)
		else $error("item advanced during bias division");

	// A run and a division never overlap
	a_run_div: assert property (@(posedge clk) disable iff (!arst_n)
		!(calibrating_q && div_busy))
		else $error("calibration run active while divider busy");

	// Finished division marks the block calibrated
	a_done_cal: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |=> calibrated_q)
		else $error("calibrated flag not set after division");

	// Starting a division leaves the run and clears the averages
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		run_end |=> (!calibrating_q && avg_x_q == '0 && avg_y_q == '0 && div_busy))
		else $error("run end did not reset smoothing state");

endmodule

`default_nettype wire

// ===== hw/rtl/absd_div.sv =====
// Constant divider of a signed magnitude by reciprocal multiplication, truncating toward zero.
`default_nettype none

module absd_div import absd_pkg::*; #(
	parameter int DIVISOR = 100,
	parameter int N_W     = 26,
	parameter int QUO_W   = 20
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [N_W-1:0]     num,
	input  wire logic               neg,
	output div_stat_t               stat,
	output logic signed [QUO_W-1:0] quo
);

	// floor(num / DIVISOR) equals (num * RECIP) >> SHIFT for every num below 2**N_W
	localparam int SHIFT = N_W + $clog2(DIVISOR);
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [N_W:0] RECIP_C = (N_W + 1)'(RECIP);

	logic             done_q;
	logic             neg_q;
	logic [N_W-1:0]   num_q;

	logic [2*N_W:0]   prod;
	logic [QUO_W-1:0] mag;

	// Quotient is ready the cycle after start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			neg_q <= neg;
		end
	end

	// Multiply by the scaled reciprocal and keep the integer part
	always_comb begin
		prod = num_q * RECIP_C;
		mag  = QUO_W'(prod >> SHIFT);
	end

	assign quo       = neg_q ? -$signed(mag) : $signed(mag);
	assign stat.busy = done_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/absd_ema.sv =====
// One axis: bias removal, exponential average, saturation and deadzone.
`default_nettype none

module absd_ema import absd_pkg::*; (
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic signed [OFFSET_W-1:0] offset,
	input  wire logic                       use_offset,
	input  wire logic signed [AVG_W-1:0]    avg,
	input  wire logic        [GAIN_W-1:0]   gain,
	input  wire logic        [DZ_W-1:0]     deadzone,
	output logic signed [AVG_W-1:0]         avg_next
);

	localparam int X_W    = OFFSET_W + 2;
	localparam int D_W    = X_W + 2;
	localparam int P_W    = D_W + GAIN_W + 1;
	localparam int STEP_W = P_W - FRAC_W;
	localparam int N_W    = STEP_W + 1;
	localparam logic signed [N_W-1:0] S_MAX = N_W'((1 <<< (AVG_W - 1)) - 1);
	localparam logic signed [N_W-1:0] S_MIN = -N_W'(1 <<< (AVG_W - 1));

	logic signed [OFFSET_W-1:0] xq;
	logic signed [X_W-1:0]      x;
	logic signed [D_W-1:0]      d;
	logic signed [P_W-1:0]      prod;
	logic signed [STEP_W-1:0]   step;
	logic signed [N_W-1:0]      n;
	logic signed [AVG_W-1:0]    n_sat;
	logic        [AVG_W:0]      mag;
	logic        [AVG_W:0]      dz_q8;

	always_comb begin
		// Q.8 sample less bias
		xq   = {sample, FRAC_W'(0)};
		x    = X_W'(xq) - (use_offset ? X_W'(offset) : X_W'(0));
		d    = D_W'(x) - D_W'(avg);
		// gain*(x-s) with floor shift
		prod = $signed({1'b0, gain}) * d;
		step = prod[P_W-1:FRAC_W];
		n    = N_W'(avg) + N_W'(step);
		// Clamp to the output range
		if (n > S_MAX)
			n_sat = AVG_W'(S_MAX);
		else if (n < S_MIN)
			n_sat = AVG_W'(S_MIN);
		else
			n_sat = n[AVG_W-1:0];
		// Deadzone on magnitude
		mag   = n_sat[AVG_W-1] ? -(AVG_W + 1)'(n_sat) : (AVG_W + 1)'(n_sat);
		dz_q8 = (AVG_W + 1)'({deadzone, FRAC_W'(0)});
		avg_next = (mag < dz_q8) ? '0 : n_sat;
	end

endmodule

`default_nettype wire

// ===== verif/tb_accel_bias_smooth_deadzone.sv =====
// Self-checking testbench for the accelerometer bias/smoothing/deadzone conditioner.
module tb_accel_bias_smooth_deadzone;
	import absd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAL_RUN       = 100;
	localparam int NUM_PHASES    = 8;
	localparam int PHASE_ITEMS   = 180;
	localparam int SETTLE_CYCLES = 40;       // bias step plus pipeline, with margin
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int MAX_PRINTS    = 50;
	localparam longint AVG_MAX   = (64'sd1 <<< (AVG_W - 1)) - 1;
	localparam longint AVG_MIN   = -(64'sd1 <<< (AVG_W - 1));

	localparam logic [ADDR_W-1:0] GAIN_ADDR = {REG_GAIN, 2'b00};
	localparam logic [ADDR_W-1:0] DZ_ADDR   = {REG_DEADZONE, 2'b00};

	typedef struct {
		logic                       kind;
		logic signed [SAMPLE_W-1:0] x_mg;
		logic signed [SAMPLE_W-1:0] y_mg;
		logic                       good;
	} accel_item_t;

	typedef struct {
		logic signed [AVG_W-1:0] x;
		logic signed [AVG_W-1:0] y;
		logic                    cal;
	} smooth_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       kind = KIND_SAMPLE;
	logic signed [SAMPLE_W-1:0] sample_x_mg = '0;
	logic signed [SAMPLE_W-1:0] sample_y_mg = '0;
	logic                       read_good = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [AVG_W-1:0]    smooth_x;
	logic signed [AVG_W-1:0]    smooth_y;
	logic                       is_calibrated;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [ADDR_W-1:0]          paddr = '0;
	logic [PDATA_W-1:0]         pwdata = '0;
	logic [PDATA_W-1:0]         prdata;
	logic                       pready;

	accel_bias_smooth_deadzone #(
		.CAL_SAMPLES(CAL_RUN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.sample_x_mg(sample_x_mg),
		.sample_y_mg(sample_y_mg),
		.read_good(read_good),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.smooth_x(smooth_x),
		.smooth_y(smooth_y),
		.is_calibrated(is_calibrated),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Predicted conditioner state and register copies
	logic [GAIN_W-1:0] gain_cfg = GAIN_RESET;
	logic [DZ_W-1:0]   dz_cfg   = DZ_RESET;
	int est_avg_x = 0;
	int est_avg_y = 0;
	int bias_x = 0;
	int bias_y = 0;
	int run_sum_x = 0;
	int run_sum_y = 0;
	int run_count = 0;
	bit in_cal_run = 1'b0;
	bit have_bias = 1'b0;

	accel_item_t pending_q[$];
	smooth_res_t expected_smooth_q[$];
	accel_item_t cur_item = '{KIND_SAMPLE, '0, '0, 1'b0};
	int n_queued = 0;
	int n_accepted = 0;
	int mism_count = 0;
	int in_gap = 0;
	int in_burst = 0;
	int rdy_hold = 0;
	int rdy_burst = 0;
	int center_x = 0;
	int center_y = 0;

	task automatic report_mismatch(input string msg);
		if (mism_count < MAX_PRINTS)
			$display("%0t mismatch: %s", $time, msg);
		mism_count++;
	endtask

	// One smoothing step: floor-shifted EMA, saturation, then deadzone
	function automatic int ema_deadzone(input int s, input int x);
		longint d;
		longint n;
		longint dz;
		d = longint'(x) - longint'(s);
		n = longint'(s) + ((longint'(gain_cfg) * d) >>> FRAC_W);
		dz = longint'(dz_cfg) * 256;
		if (n > AVG_MAX)
			n = AVG_MAX;
		if (n < AVG_MIN)
			n = AVG_MIN;
		if ((n < 0 ? -n : n) < dz)
			n = 0;
		return int'(n);
	endfunction

	// Advance the predicted state by one accepted item, queue any result
	task automatic apply_accel_item(input accel_item_t it);
		smooth_res_t res;
		int xq;
		int yq;
		if (it.kind == KIND_CAL) begin
			// start or restart a bias run
			in_cal_run = 1'b1;
			run_count = 0;
			run_sum_x = 0;
			run_sum_y = 0;
		end else if (in_cal_run) begin
			if (it.good) begin
				run_sum_x += it.x_mg;
				run_sum_y += it.y_mg;
			end
			run_count++;
			if (run_count >= CAL_RUN) begin
				bias_x = (run_sum_x * 256) / CAL_RUN;
				bias_y = (run_sum_y * 256) / CAL_RUN;
				est_avg_x = 0;
				est_avg_y = 0;
				have_bias = 1'b1;
				in_cal_run = 1'b0;
				run_count = 0;
			end
		end else if (it.good) begin
			xq = it.x_mg * 256;
			yq = it.y_mg * 256;
			if (have_bias) begin
				xq -= bias_x;
				yq -= bias_y;
			end
			est_avg_x = ema_deadzone(est_avg_x, xq);
			est_avg_y = ema_deadzone(est_avg_y, yq);
			res.x = AVG_W'(est_avg_x);
			res.y = AVG_W'(est_avg_y);
			res.cal = have_bias;
			expected_smooth_q = {expected_smooth_q, res};
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// Input driver: one transfer per handshake, random gaps between items
	always @(posedge clk) begin : feed
		logic hold;
		if (arst_n) begin
			hold = in_valid;
			if (in_valid && in_ready) begin
				apply_accel_item(cur_item);
				n_accepted++;
				hold = 1'b0;
				if (in_burst != 0) begin
					in_burst--;
					in_gap = 0;
				end else if ($urandom_range(0, 39) == 0) begin
					in_burst = $urandom_range(20, 80);
					in_gap = 0;
				end else if ($urandom_range(0, 1) == 0) begin
					in_gap = 0;
				end else begin
					in_gap = pick_gap();
				end
			end
			if (!hold) begin
				if (in_gap != 0) begin
					in_gap--;
				end else if (pending_q.size() != 0) begin
					cur_item = pending_q.pop_front();
					hold = 1'b1;
				end
			end
			in_valid    <= hold;
			kind        <= cur_item.kind;
			sample_x_mg <= cur_item.x_mg;
			sample_y_mg <= cur_item.y_mg;
			read_good   <= cur_item.good;
		end
	end

	// Result monitor and receiver back-pressure
	always @(posedge clk) begin : check
		smooth_res_t want;
		logic rdy;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_smooth_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result x=%0d y=%0d cal=%0b",
						smooth_x, smooth_y, is_calibrated));
				end else begin
					want = expected_smooth_q.pop_front();
					if (smooth_x !== want.x)
						report_mismatch($sformatf("smooth_x got %0d expected %0d",
							smooth_x, want.x));
					if (smooth_y !== want.y)
						report_mismatch($sformatf("smooth_y got %0d expected %0d",
							smooth_y, want.y));
					if (is_calibrated !== want.cal)
						report_mismatch($sformatf("is_calibrated got %0b expected %0b",
							is_calibrated, want.cal));
				end
			end
			if (rdy_hold != 0) begin
				rdy_hold--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				if (rdy_burst != 0)
					rdy_burst--;
				else if ($urandom_range(0, 19) == 0)
					rdy_burst = $urandom_range(20, 80);
				else if ($urandom_range(0, 3) == 0)
					rdy_hold = pick_gap();
			end
			out_ready <= rdy;
		end
	end

	// Register access: setup cycle, then access cycle
	task automatic apb_write(input logic [ADDR_W-1:0] addr, input int val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= PDATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_check(input logic [ADDR_W-1:0] addr, input logic [PDATA_W-1:0] want);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			report_mismatch($sformatf("register read at %0d got %0d expected %0d",
				addr, prdata, want));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic queue_item(input logic k, input int x, input int y, input logic good);
		accel_item_t it;
		it.kind = k;
		it.x_mg = SAMPLE_W'(x);
		it.y_mg = SAMPLE_W'(y);
		it.good = good;
		pending_q = {pending_q, it};
		n_queued++;
	endtask

	function automatic int rand_mg();
		return int'($urandom_range(0, 4095)) - 2048;
	endfunction

	function automatic int near_mg(input int c, input int w);
		int v;
		v = c + int'($urandom_range(0, 2 * w)) - w;
		if (v > 2047)
			v = 2047;
		if (v < -2048)
			v = -2048;
		return v;
	endfunction

	// Full bias run: calibrate item with junk fields, then CAL_RUN attempts
	task automatic queue_cal_run(input int mode);
		int cx;
		int cy;
		cx = int'($urandom_range(0, 1400)) - 700;
		cy = int'($urandom_range(0, 1400)) - 700;
		queue_item(KIND_CAL, rand_mg(), rand_mg(), $urandom_range(0, 1) == 1);
		for (int i = 0; i < CAL_RUN; i++) begin
			case (mode)
				0: queue_item(KIND_SAMPLE, rand_mg(), rand_mg(), $urandom_range(0, 9) != 0);
				1: queue_item(KIND_SAMPLE, 2047, 2047, 1'b1);
				2: queue_item(KIND_SAMPLE, -2048, -2048, 1'b1);
				3: queue_item(KIND_SAMPLE, near_mg(cx, 40), near_mg(cy, 40),
					$urandom_range(0, 4) != 0);
				default: queue_item(KIND_SAMPLE, rand_mg(), rand_mg(), 1'b0);
			endcase
		end
		case (mode)
			1: begin
				center_x = 2047;
				center_y = 2047;
			end
			2: begin
				center_x = -2048;
				center_y = -2048;
			end
			3: begin
				center_x = cx;
				center_y = cy;
			end
			default: ;
		endcase
	endtask

	// Samples outside a run: random, near the bias, or rail to rail
	task automatic queue_burst(input int n, input int mode);
		int w;
		w = $urandom_range(0, 80);
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: queue_item(KIND_SAMPLE, rand_mg(), rand_mg(), $urandom_range(0, 6) != 0);
				1: queue_item(KIND_SAMPLE, near_mg(center_x, w), near_mg(center_y, w),
					$urandom_range(0, 9) != 0);
				default: queue_item(KIND_SAMPLE,
					$urandom_range(0, 1) ? 2047 : -2048,
					$urandom_range(0, 1) ? 2047 : -2048, 1'b1);
			endcase
		end
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || expected_smooth_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Watchdog
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("accel_bias_smooth_deadzone verification failed");
		$finish;
	end

	// Stimulus sequence
	initial begin : stim
		int gain_v;
		int dz_v;
		int base;
		int pick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: no bias yet, field extremes, failed read, run start and restart
		queue_item(KIND_SAMPLE, 0, 0, 1'b1);
		queue_item(KIND_SAMPLE, 2047, 2047, 1'b1);
		queue_item(KIND_SAMPLE, -2048, -2048, 1'b1);
		queue_item(KIND_SAMPLE, 2047, -2048, 1'b1);
		queue_item(KIND_SAMPLE, -2048, 2047, 1'b0);
		queue_item(KIND_SAMPLE, 1, -1, 1'b1);
		queue_item(KIND_SAMPLE, -1, 1, 1'b1);
		queue_item(KIND_SAMPLE, 1365, -1366, 1'b1);
		queue_item(KIND_CAL, -1366, 1365, 1'b1);
		queue_item(KIND_SAMPLE, 100, -100, 1'b1);
		queue_item(KIND_SAMPLE, 5, 5, 1'b0);
		queue_item(KIND_CAL, 0, 0, 1'b0);
		queue_item(KIND_SAMPLE, -2048, 2047, 1'b1);
		wait_drained();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// Phase 0 keeps the reset settings
			if (ph != 0) begin
				case (ph)
					1: begin
						gain_v = 0;
						dz_v = 0;
					end
					2: begin
						gain_v = 256;
						dz_v = 255;
					end
					3: begin
						gain_v = 511;
						dz_v = 0;
					end
					4: begin
						gain_v = 1;
						dz_v = 1;
					end
					5: begin
						gain_v = 128;
						dz_v = 40;
					end
					6: begin
						gain_v = $urandom_range(0, 511);
						dz_v = $urandom_range(0, 255);
					end
					default: begin
						gain_v = 511;
						dz_v = 255;
					end
				endcase
				apb_write(GAIN_ADDR, gain_v);
				gain_cfg = GAIN_W'(gain_v);
				apb_write(DZ_ADDR, dz_v);
				dz_cfg = DZ_W'(dz_v);
			end
			apb_check(GAIN_ADDR, PDATA_W'(gain_cfg));
			apb_check(DZ_ADDR, PDATA_W'(dz_cfg));

			base = n_queued;
			queue_cal_run(ph % 5);
			while (n_queued - base < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					queue_cal_run($urandom_range(0, 4));
				end else if (pick < 14) begin
					// broken run: following items finish or restart it
					queue_item(KIND_CAL, rand_mg(), rand_mg(), 1'b1);
					queue_burst($urandom_range(1, CAL_RUN - 1), 0);
				end else if (pick < 50) begin
					queue_burst($urandom_range(4, 30), 1);
				end else if (pick < 85) begin
					queue_burst($urandom_range(4, 30), 0);
				end else begin
					queue_burst($urandom_range(4, 30), 2);
				end
			end
			wait_drained();
		end

		if (mism_count == 0) begin
			$display("accel_bias_smooth_deadzone verification clean");
		end else begin
			$display("accel_bias_smooth_deadzone verification failed");
		end
		$finish;
	end

endmodule
